// ===== rtl/ptrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_pkg: shared types and constants of the periodic task scheduler
// Slot table geometry, operation and status codes, slot entry layout and
// the constants of the millisecond to tick conversion.
// ----------------------------------------------------------------------------
package ptrs_pkg;

	localparam int SLOT_COUNT = 10;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

	localparam int TIME_W    = 16;
	localparam int RATE_W    = 10;
	localparam int SLOTF_W   = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CMP_W     = (CNT_W > SLOTF_W) ? CNT_W : SLOTF_W;

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);

	// ticks = (ms * rate) / 1000; 1000 = 8 * 125, the /125 by reciprocal
	localparam int MS_PER_S    = 1000;
	localparam int PRE_SHIFT   = 3;
	localparam int ODD_DIV     = MS_PER_S >> PRE_SHIFT;
	localparam int RECIP_SHIFT = 30;
	localparam int RECIP_W     = 24;
	localparam int PROD_W      = TIME_W + RATE_W;
	localparam int Q_W         = PROD_W - PRE_SHIFT + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_MUL =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(ODD_DIV) - 64'd1) / 64'(ODD_DIV));

	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_DISPATCH   = 3'd1,
		OP_ADD        = 3'd2,
		OP_ENABLE     = 3'd3,
		OP_DISABLE    = 3'd4,
		OP_SET_PERIOD = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_EMPTY   = 2'd1,
		STATUS_NO_SLOT = 2'd2,
		STATUS_FULL    = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RUNNING = 2'd0,
		CFG_RATE    = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] countdown;
		logic [TIME_W-1:0] delay;
		logic              enabled;
		logic              ready;
	} slot_entry_t;

	localparam int ENTRY_W = $bits(slot_entry_t);

	typedef struct packed {
		status_t            status;
		logic [SLOTF_W-1:0] slot;
		logic               fired;
	} result_t;

endpackage

// ===== rtl/ptrs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_ram: generic single-clock RAM
// One write port, one read port with registered read data that holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module ptrs_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/ptrs_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_conv: millisecond to tick converter
// Two-stage pipeline: ms * rate, then divide by 1000 as a shift by three
// and an exact reciprocal multiply by 1/125. Result truncated to 16 bits.
// ----------------------------------------------------------------------------
module ptrs_conv
	import ptrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] ms,
	input  logic [RATE_W-1:0] rate,
	output logic              done,
	output logic [TIME_W-1:0] ticks
);

	logic              vld_s1, vld_s2;
	logic [PROD_W-1:0] prod_s1;
	logic [Q_W-1:0]    q_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(ms) * PROD_W'(rate);
		q_s2    <= Q_W'(prod_s1[PROD_W-1:PRE_SHIFT]) * Q_W'(RECIP_MUL);
	end

	assign done  = vld_s2;
	assign ticks = q_s2[RECIP_SHIFT +: TIME_W];

endmodule

// ===== rtl/periodic_task_ready_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_ready_scheduler: table of periodic task slots
// Tick, dispatch, add, enable, disable and set period on a slot table kept
// in one RAM, with a status or fired-slot result stream.
// ----------------------------------------------------------------------------
// One item is taken at a time. Tick and dispatch walk the live slots (those
// before the first zero period) through the slot RAM, one slot per cycle
// unless a fired slot waits for the output register: read a slot, then
// write it back while the next one is read. Add and set period wait for
// the two-stage ms-to-tick converter. A tick while stopped or on an empty
// table, or an unused code, leaves the block idle and gives no result; a
// stopped dispatch and a rejected add or command go straight to the
// flush state. Results sit in an output register, so the next item is
// accepted while a result waits.
// Dispatch holds each fired slot back by one so that the last one carries
// last_result. The RAM needs no clearing: a slot is only read once it is
// live, and it only becomes live by an add that writes all of it.
// ----------------------------------------------------------------------------
module periodic_task_ready_scheduler
	import ptrs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           operation,
	input  logic [SLOTF_W-1:0]   slot_index,
	input  logic [TIME_W-1:0]    delay_ms,
	input  logic [TIME_W-1:0]    period_ms,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status_code,
	output logic [SLOTF_W-1:0]   fired_slot,
	output logic                 fired_valid,
	output logic                 last_result,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RATE_W-1:0]    cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_MOD,
		ST_CONV,
		ST_FLUSH
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  live_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              rd_s1;
	logic [IDX_W-1:0]  idx_s1;
	result_t           pend_q;
	logic              pend_full_q;
	result_t           out_q;
	logic              out_last_q;
	logic              out_valid_q;
	logic              running_q;
	logic [RATE_W-1:0] rate_q;
	logic [CNT_W-1:0]  added_q;
	logic [SLOT_COUNT-1:0] period_nz_q;   // mirror of period != 0 per slot

	// RAM port
	logic               ram_we, ram_re;
	logic [IDX_W-1:0]   ram_waddr, ram_raddr;
	slot_entry_t        ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	slot_entry_t        rd_ent;

	// converters
	logic              conv_start;
	logic              dconv_done, pconv_done, conv_done;
	logic [TIME_W-1:0] d_ticks, p_ticks;

	// control
	logic             accept;
	op_t              in_op;
	logic [CNT_W-1:0] live;
	logic             cmd_op, cmd_empty, cmd_noslot, add_full;
	logic             out_free;
	logic             proc, fire, walk_block, more;
	slot_entry_t      tick_ent, disp_ent;

	ptrs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOT_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ptrs_conv u_dconv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (conv_start),
		.ms    (delay_ms),
		.rate  (rate_q),
		.done  (dconv_done),
		.ticks (d_ticks)
	);

	ptrs_conv u_pconv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (conv_start),
		.ms    (period_ms),
		.rate  (rate_q),
		.done  (pconv_done),
		.ticks (p_ticks)
	);

	assign rd_ent    = slot_entry_t'(ram_rdata);
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign in_op     = op_t'(operation);
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// both converters start together, so they finish together
	assign conv_done = dconv_done && pconv_done;

	// live count: index of the first slot with a zero period
	always_comb begin
		live = CNT_W'(SLOT_COUNT);
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!period_nz_q[i]) begin
				live = CNT_W'(i);
			end
		end
	end

	assign cmd_op     = (in_op == OP_ENABLE) || (in_op == OP_DISABLE) ||
	                    (in_op == OP_SET_PERIOD);
	assign cmd_empty  = (live == '0);
	assign cmd_noslot = CMP_W'(slot_index) >= CMP_W'(live);
	assign add_full   = (added_q >= CNT_W'(SLOT_COUNT)) || (live >= CNT_W'(SLOT_COUNT));

	// converters only run for items that will use the result
	assign conv_start = accept && (((in_op == OP_ADD) && !add_full) ||
	                    ((in_op == OP_SET_PERIOD) && !cmd_empty && !cmd_noslot));

	// slot walk
	assign proc       = (state_q == ST_WALK) && rd_s1;
	assign fire       = (op_q == OP_DISPATCH) && rd_ent.ready && rd_ent.enabled;
	assign walk_block = proc && fire && pend_full_q && !out_free;
	assign more       = rd_idx_q < live_q;

	always_comb begin
		tick_ent = rd_ent;
		if (rd_ent.delay != '0) begin
			tick_ent.delay = rd_ent.delay - TIME_W'(1);
		end else begin
			tick_ent.countdown = rd_ent.countdown - TIME_W'(1);
			// countdown wrapping from zero leaves the ready mark as it was
			if (tick_ent.countdown == '0) begin
				tick_ent.ready = 1'b1;
			end
		end
	end

	always_comb begin
		disp_ent = rd_ent;
		if (fire) begin
			disp_ent.ready     = 1'b0;
			disp_ent.countdown = rd_ent.period;
		end
	end

	// RAM access
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = rd_ent;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd_op && !cmd_empty && !cmd_noslot) begin
					ram_re    = 1'b1;
					ram_raddr = IDX_W'(slot_index);
				end
			end
			ST_WALK: begin
				if (!walk_block) begin
					if (proc) begin
						ram_we    = 1'b1;
						ram_waddr = idx_s1;
						ram_wdata = (op_q == OP_TICK) ? tick_ent : disp_ent;
					end
					if (more) begin
						ram_re    = 1'b1;
						ram_raddr = rd_idx_q[IDX_W-1:0];
					end
				end
			end
			ST_MOD: begin
				ram_we            = 1'b1;
				ram_waddr         = idx_q;
				ram_wdata.enabled = (op_q == OP_ENABLE);
			end
			ST_CONV: begin
				if (conv_done) begin
					ram_we = 1'b1;
					if (op_q == OP_ADD) begin
						ram_waddr           = live_q[IDX_W-1:0];
						ram_wdata.period    = p_ticks;
						ram_wdata.countdown = p_ticks;
						ram_wdata.delay     = d_ticks;
						ram_wdata.enabled   = 1'b1;
						ram_wdata.ready     = 1'b0;
					end else begin
						ram_waddr        = idx_q;
						ram_wdata.period = p_ticks;
					end
				end
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_TICK;
			idx_q       <= '0;
			live_q      <= '0;
			rd_idx_q    <= '0;
			rd_s1       <= 1'b0;
			idx_s1      <= '0;
			pend_q      <= '0;
			pend_full_q <= 1'b0;
			out_q       <= '0;
			out_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
			running_q   <= 1'b0;
			rate_q      <= RATE_RESET;
			added_q     <= '0;
			period_nz_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RUNNING: running_q <= cfg_data[0];
					CFG_RATE:    rate_q    <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q        <= in_op;
						idx_q       <= IDX_W'(slot_index);
						live_q      <= live;
						rd_idx_q    <= '0;
						rd_s1       <= 1'b0;
						pend_full_q <= 1'b0;
						case (in_op)
							OP_TICK: begin
								if (running_q && !cmd_empty) begin
									state_q <= ST_WALK;
								end
							end
							OP_DISPATCH: begin
								// stopped: straight to the no-task result
								state_q <= running_q ? ST_WALK : ST_FLUSH;
							end
							OP_ADD: begin
								if (add_full) begin
									pend_q      <= '{STATUS_FULL, '0, 1'b0};
									pend_full_q <= 1'b1;
									state_q     <= ST_FLUSH;
								end else begin
									state_q <= ST_CONV;
								end
							end
							OP_ENABLE, OP_DISABLE, OP_SET_PERIOD: begin
								if (cmd_empty) begin
									pend_q      <= '{STATUS_EMPTY, '0, 1'b0};
									pend_full_q <= 1'b1;
									state_q     <= ST_FLUSH;
								end else if (cmd_noslot) begin
									pend_q      <= '{STATUS_NO_SLOT, '0, 1'b0};
									pend_full_q <= 1'b1;
									state_q     <= ST_FLUSH;
								end else begin
									state_q <= (in_op == OP_SET_PERIOD) ? ST_CONV : ST_MOD;
								end
							end
							default: ;   // unused codes: no result
						endcase
					end
				end

				ST_WALK: begin
					if (!walk_block) begin
						if (proc && fire) begin
							// push the held fired slot out, hold the new one
							if (pend_full_q) begin
								out_q       <= pend_q;
								out_last_q  <= 1'b0;
								out_valid_q <= 1'b1;
							end
							pend_q      <= '{STATUS_OK, SLOTF_W'(idx_s1), 1'b1};
							pend_full_q <= 1'b1;
						end
						if (more) begin
							rd_s1    <= 1'b1;
							idx_s1   <= rd_idx_q[IDX_W-1:0];
							rd_idx_q <= rd_idx_q + CNT_W'(1);
						end else begin
							rd_s1 <= 1'b0;
						end
						if (!proc && !more) begin
							state_q <= (op_q == OP_TICK) ? ST_IDLE : ST_FLUSH;
						end
					end
				end

				ST_MOD: begin
					pend_q      <= '{STATUS_OK, '0, 1'b0};
					pend_full_q <= 1'b1;
					state_q     <= ST_FLUSH;
				end

				ST_CONV: begin
					if (conv_done) begin
						if (op_q == OP_ADD) begin
							added_q                          <= added_q + CNT_W'(1);
							period_nz_q[live_q[IDX_W-1:0]]   <= (p_ticks != '0);
							pend_q <= '{STATUS_OK, SLOTF_W'(live_q), 1'b0};
						end else begin
							period_nz_q[idx_q] <= (p_ticks != '0);
							pend_q             <= '{STATUS_OK, '0, 1'b0};
						end
						pend_full_q <= 1'b1;
						state_q     <= ST_FLUSH;
					end
				end

				ST_FLUSH: begin
					if (out_free) begin
						out_q       <= pend_full_q ? pend_q : '{STATUS_OK, '0, 1'b0};
						out_last_q  <= 1'b1;
						out_valid_q <= 1'b1;
						pend_full_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status_code = out_q.status;
	assign fired_slot  = out_q.slot;
	assign fired_valid = out_q.fired;
	assign last_result = out_last_q;

endmodule

// ===== rtl/ptrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_checker: port-level checks of the task scheduler
// Watches the result stream and request handshake; bound to the top level.
// ----------------------------------------------------------------------------
module ptrs_checker
	import ptrs_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [2:0]           operation,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [1:0]           status_code,
	input logic [SLOTF_W-1:0]   fired_slot,
	input logic                 fired_valid,
	input logic                 last_result
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status_code) &&
		$stable(fired_slot) && $stable(fired_valid) && $stable(last_result))
		else $error("stalled result changed");

	// only a dispatch produces several results; each one before the last is a fired slot
	a_mid_fired: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_result |-> fired_valid)
		else $error("non-final result without a fired slot");

	// fired slots always report ok
	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fired_valid |-> status_code == STATUS_OK)
		else $error("fired slot with error status");

	// a dispatch always has results to deliver, so the block goes busy
	a_disp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && operation == OP_DISPATCH |=> in_stall)
		else $error("dispatch accepted without going busy");

endmodule

bind periodic_task_ready_scheduler ptrs_checker u_ptrs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.operation  (operation),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status_code(status_code),
	.fired_slot (fired_slot),
	.fired_valid(fired_valid),
	.last_result(last_result)
);
